@@ rtl/core/crc_pkg.sv @@
// Package for the connection rule classifier: payload structs, op codes and rule type.
// No dependencies.
package crc_pkg;

    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_APPEND   = 2'd1;
    localparam logic [1:0] OP_PREPEND  = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam int SEL_FAMILY = 0;
    localparam int SEL_TIME   = 1;
    localparam int SEL_LOCAL  = 2;
    localparam int SEL_REMOTE = 3;
    localparam int SEL_STATE  = 4;
    localparam int SEL_ADDR   = 5;
    localparam int SEL_PORT   = 6;

    localparam logic signed [32:0] TIME_WINDOW = 33'sd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  selectors;
        logic [3:0]  action;
        logic        is_ipv6;
        logic [63:0] local_addr_hi;
        logic [63:0] local_addr_lo;
        logic [15:0] local_port;
        logic [63:0] remote_addr_hi;
        logic [63:0] remote_addr_lo;
        logic [15:0] remote_port;
        logic [3:0]  conn_state;
        logic [31:0] time_stamp;
    } in_word_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  rule_position;
        logic [3:0]  result_action;
        logic [31:0] hit_total;
        logic        table_full;
    } out_word_t;

    // One stored rule together with its counters.
    typedef struct packed {
        logic [6:0]  selectors;
        logic [3:0]  action;
        logic        family;
        logic [63:0] local_hi;
        logic [63:0] local_lo;
        logic [63:0] remote_hi;
        logic [63:0] remote_lo;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [3:0]  conn_state;
        logic [31:0] stamp;
        logic [31:0] eval_total;
        logic [31:0] hit_total;
    } rule_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic load;     // write a new rule into the addressed cell
        logic shift;    // prepend: every cell takes its left neighbor
        logic eval;     // classify: bump counters of tested cells
    } cell_cmd_t;

endpackage

@@ rtl/core/crc_cell.sv @@
// One rule cell: holds a rule, tests it against the broadcast connection, keeps counters.
// Depends on crc_pkg.
module crc_cell (
    input  logic             clk,
    input  crc_pkg::cell_cmd_t cmd,
    input  logic             load_here,
    input  logic             tested,
    input  crc_pkg::in_word_t conn,
    input  crc_pkg::in_word_t add_word,
    input  crc_pkg::rule_t   left_rule,
    output crc_pkg::rule_t   rule,
    output logic             match
);
    import crc_pkg::*;

    rule_t rule_reg;
    rule_t new_rule;
    logic  fam_ok, time_ok, loc_ok, rem_ok, st_ok, any_sel;
    logic signed [32:0] diff;

    function automatic logic side_ok(input logic [6:0] sel, input logic rfam,
                                     input logic [63:0] rhi, input logic [63:0] rlo,
                                     input logic [15:0] rport, input logic cfam,
                                     input logic [63:0] chi, input logic [63:0] clo,
                                     input logic [15:0] cport);
        logic ok;
        begin
            ok = 1'b1;
            if (sel[SEL_ADDR])
            begin
                if (rfam != cfam)
                    ok = 1'b0;
                else if (rfam)
                    ok = (rhi == chi) && (rlo == clo);
                else
                    ok = (rlo[31:0] == clo[31:0]);
            end
            if (sel[SEL_PORT])
                ok = ok && (rport == cport);
            side_ok = ok;
        end
    endfunction

    // A new rule is built from the word being accepted, not from the latched connection.
    always_comb
    begin
        new_rule.selectors   = add_word.selectors;
        new_rule.action      = add_word.action;
        new_rule.family      = add_word.is_ipv6;
        new_rule.local_hi    = add_word.local_addr_hi;
        new_rule.local_lo    = add_word.local_addr_lo;
        new_rule.remote_hi   = add_word.remote_addr_hi;
        new_rule.remote_lo   = add_word.remote_addr_lo;
        new_rule.local_port  = add_word.local_port;
        new_rule.remote_port = add_word.remote_port;
        new_rule.conn_state  = add_word.conn_state;
        new_rule.stamp       = add_word.time_stamp;
        new_rule.eval_total  = 32'd0;
        new_rule.hit_total   = 32'd0;
    end

    assign diff    = $signed({1'b0, conn.time_stamp}) - $signed({1'b0, rule_reg.stamp});
    assign fam_ok  = !rule_reg.selectors[SEL_FAMILY] || (conn.is_ipv6 == rule_reg.family);
    assign time_ok = !rule_reg.selectors[SEL_TIME] || (diff < TIME_WINDOW);
    assign loc_ok  = !rule_reg.selectors[SEL_LOCAL] ||
                     side_ok(rule_reg.selectors, rule_reg.family, rule_reg.local_hi,
                             rule_reg.local_lo, rule_reg.local_port, conn.is_ipv6,
                             conn.local_addr_hi, conn.local_addr_lo, conn.local_port);
    assign rem_ok  = !rule_reg.selectors[SEL_REMOTE] ||
                     side_ok(rule_reg.selectors, rule_reg.family, rule_reg.remote_hi,
                             rule_reg.remote_lo, rule_reg.remote_port, conn.is_ipv6,
                             conn.remote_addr_hi, conn.remote_addr_lo, conn.remote_port);
    assign st_ok   = !rule_reg.selectors[SEL_STATE] || (rule_reg.conn_state == conn.conn_state);
    assign any_sel = rule_reg.selectors[SEL_TIME] | rule_reg.selectors[SEL_LOCAL] |
                     rule_reg.selectors[SEL_REMOTE] | rule_reg.selectors[SEL_STATE];
    assign match   = fam_ok && time_ok && loc_ok && rem_ok && st_ok && any_sel;

    // Rule contents have no reset; only cells below the fill count are ever read.
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_here)
            rule_reg <= new_rule;
        else if (cmd.shift)
            rule_reg <= left_rule;
        else if (cmd.eval && tested)
        begin
            rule_reg.eval_total <= rule_reg.eval_total + 32'd1;
            if (match)
                rule_reg.hit_total <= rule_reg.hit_total + 32'd1;
        end
    end

    assign rule = rule_reg;

endmodule

@@ rtl/core/connection_rule_classifier.sv @@
// Top level of the connection rule classifier: controller, row of rule cells, output register.
// Depends on crc_pkg and crc_cell.
//
// Usage: input words arrive on in_valid/in_ready/in_data; op selects classify, append or
// prepend. Every input word yields exactly one output word on out_valid/out_ready/out_data.
// The rules live in a row of RULE_SLOTS cells; each cell compares its rule against the
// broadcast connection in parallel. A prepend shifts every rule one cell to the right
// and writes cell 0; an append writes the cell at the fill count.
// A classify latches the connection at acceptance; in the next cycle every cell reports a
// match, a priority pick (first or last valid match, by first_match_mode) selects the
// winner, and the tested cells update their evaluation and hit counters. The result is
// registered. An add or an unused op shows out_valid in the cycle right after acceptance,
// a classify in the cycle after its evaluate cycle. The input is held until the result
// has been delivered, so no new word is taken while a word is still in evaluation or
// its result waits in the output register.
// The configuration channel cfg_valid/cfg_ready/cfg_data writes first_match_mode.
// Reset clears the fill count and sets first_match_mode to 1; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register and no new input word
// is taken until it is delivered.
module connection_rule_classifier #(
    parameter int RULE_SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  crc_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output crc_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import crc_pkg::*;

    localparam int IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CW = $clog2(RULE_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    in_word_t          conn_reg;
    logic [CW-1:0]     count_reg;
    logic              mode_reg;
    out_word_t         out_reg, out_next;
    logic              out_valid_reg;
    cell_cmd_t         cmd;
    rule_t             rules [RULE_SLOTS];
    logic [RULE_SLOTS-1:0] match_vec, tested_vec, load_vec;
    logic              found;
    logic [IW-1:0]     win;
    logic              accept, is_add, full;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign is_add    = (in_data.op == OP_APPEND) || (in_data.op == OP_PREPEND);
    assign full      = (count_reg == CW'(RULE_SLOTS));

    always_comb
    begin
        cmd.load  = accept && is_add && !full;
        cmd.shift = accept && (in_data.op == OP_PREPEND) && !full;
        cmd.eval  = (state_reg == ST_EVAL);
    end

    genvar g;
    generate
        for (g = 0; g < RULE_SLOTS; g++)
        begin : g_cell
            rule_t left;
            if (g == 0)
            begin : g_first
                assign left = rules[0];
            end
            else
            begin : g_rest
                assign left = rules[g-1];
            end
            assign load_vec[g] = (in_data.op == OP_PREPEND) ? (g == 0)
                                 : (count_reg == CW'(g));
            crc_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .load_here (load_vec[g]),
                .tested    (tested_vec[g]),
                .conn      (conn_reg),
                .add_word  (in_data),
                .left_rule (left),
                .rule      (rules[g]),
                .match     (match_vec[g])
            );
        end
    endgenerate

    // Priority pick over the valid match bits, and the set of cells the walk reaches.
    always_comb
    begin
        found = 1'b0;
        win   = '0;
        tested_vec = '0;
        for (int i = 0; i < RULE_SLOTS; i++)
        begin
            if (CW'(i) < count_reg && !(mode_reg && found))
            begin
                tested_vec[i] = 1'b1;
                if (match_vec[i])
                begin
                    found = 1'b1;
                    win   = IW'(i);
                end
            end
        end
    end

    always_comb
    begin
        out_next = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.op == OP_CLASSIFY)
                        state_next = ST_EVAL;
                    else if (is_add && full)
                        out_next.table_full = 1'b1;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
                if (found)
                begin
                    out_next.hit           = 1'b1;
                    out_next.rule_position = 4'(win);
                    out_next.result_action = rules[win].action;
                    out_next.hit_total     = rules[win].hit_total + 32'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mode_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                mode_reg <= cfg_data;
            if (cmd.load)
                count_reg <= count_reg + CW'(1);
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            else if ((accept && in_data.op != OP_CLASSIFY) || state_reg == ST_EVAL)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            conn_reg <= in_data;
        if ((accept && in_data.op != OP_CLASSIFY) || state_reg == ST_EVAL)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RULE_SLOTS))
        else $error("fill count beyond table size");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> !in_ready)
        else $error("input taken during evaluation");
    a_eval_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |=> out_valid)
        else $error("classify produced no result");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> count_reg == CW'(RULE_SLOTS))
        else $error("fill count changed on full table");

endmodule
